// ----- src/sha_pkg.sv -----
// Package with SHA-256 constants, a rotate function and shared types.
`default_nettype none
package sha_pkg;

	localparam int WordW = 32;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_FILL = 6'd56;

	typedef logic [31:0] word_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} core_ctl_t;

	function automatic word_t ror(input word_t v, input int s);
		ror = (v >> s) | (v << (32 - s));
	endfunction

endpackage
`default_nettype wire

// ----- src/sha_core.sv -----
// SHA-256 compression core, one round per cycle over a 16-word schedule window.
`default_nettype none
module sha_core
	import sha_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  word_t      blk [16],
	input  word_t      h_in [8],
	output logic       busy,
	output logic       done,
	output word_t      h_out [8]
);

	word_t w_q [16];
	word_t a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [5:0] rnd_q;
	logic fin_q;

	word_t s0, s1, t1, t2, wn, bs0, bs1;

	always_comb begin
		bs1 = ror(e_q, 6) ^ ror(e_q, 11) ^ ror(e_q, 25);
		bs0 = ror(a_q, 2) ^ ror(a_q, 13) ^ ror(a_q, 22);
		t1 = h_q + bs1 + ((e_q & f_q) ^ (~e_q & g_q)) + ROUND_K[rnd_q] + w_q[0];
		t2 = bs0 + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
		s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			fin_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start && !busy) begin
				busy <= 1'b1;
				rnd_q <= '0;
			end else if (busy) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk[i];
			a_q <= h_in[0]; b_q <= h_in[1]; c_q <= h_in[2]; d_q <= h_in[3];
			e_q <= h_in[4]; f_q <= h_in[5]; g_q <= h_in[6]; h_q <= h_in[7];
		end else if (busy) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	assign done = fin_q;
	assign h_out[0] = h_in[0] + a_q;
	assign h_out[1] = h_in[1] + b_q;
	assign h_out[2] = h_in[2] + c_q;
	assign h_out[3] = h_in[3] + d_q;
	assign h_out[4] = h_in[4] + e_q;
	assign h_out[5] = h_in[5] + f_q;
	assign h_out[6] = h_in[6] + g_q;
	assign h_out[7] = h_in[7] + h_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without a running block");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && rnd_q != 6'd63) |=> busy) else $error("core stopped early");
	a_rnd_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> rnd_q == 6'd0) else $error("round counter not cleared");

endmodule
`default_nettype wire

// ----- src/sha256_stream_hasher.sv -----
// Top level of the SHA-256 stream hasher: byte gathering, padding, digest output.
//
// Usage: message words arrive on the s_axis channel, tdata = data_word (first
// byte in bits 31..24) then byte_count, tlast = end_of_message. s_axis_tready is
// high while the block can take a word. Each accepted word is placed one byte
// per cycle into the 64-byte block buffer, pausing while a full buffer is
// compressed; the next word is taken only once the last one is placed. When the
// buffer fills, the shared round unit is launched, runs 64 rounds, and the
// result is folded into the hash state. At end of message the padding bytes
// are written one per cycle, pausing while a full block is compressed, then the
// length is written; the padding spans one or two blocks. The eight digest words
// then leave on m_axis, one per transfer, with tuser = length_error and tlast on
// the eighth word. A stalled receiver holds the current digest word on the
// output; no new input is taken until all eight are transferred. Throughput
// is set by the byte loop and the round loop.
// Reset restores the initial hash values, clears the fill count and byte count,
// and empties the output.
`default_nettype none
module sha256_stream_hasher
	import sha_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [39:0] s_axis_tdata,  // data_word[31:0], byte_count[34:32], zero
	input  wire         s_axis_tlast,  // end_of_message
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,  // digest_word[31:0], word_index[34:32], zero
	output logic        m_axis_tlast,  // last_word
	output logic        m_axis_tuser   // length_error
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BYTE = 3'd1;
	localparam logic [2:0] ST_PAD  = 3'd2;
	localparam logic [2:0] ST_COMP = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] st_q;
	word_t hs_q [8];
	word_t buf_q [16];
	logic [5:0] fill_q;
	logic [63:0] tot_q;
	logic ovf_q, err_q;
	word_t data_q;
	logic [2:0] cnt_q;
	logic eom_q, padding_q, final_q;
	logic [2:0] oidx_q;
	core_ctl_t ctl;
	word_t h_new [8];

	logic [2:0] in_cnt;
	logic [7:0] cur_byte;
	logic [3:0] widx;
	logic [4:0] sh;
	logic [63:0] bits;

	assign in_cnt = (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
	assign widx = fill_q[5:2];
	assign sh = 5'd24 - {fill_q[1:0], 3'b000};
	assign cur_byte = padding_q ? 8'h00 : data_q[31:24];
	assign bits = {tot_q[60:0], 3'b000};

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .start(ctl.start), .blk(buf_q), .h_in(hs_q),
		.busy(ctl.busy), .done(ctl.done), .h_out(h_new)
	);

	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata = {5'd0, oidx_q, hs_q[oidx_q]};
	assign m_axis_tlast = (oidx_q == 3'd7);
	assign m_axis_tuser = err_q;

	always_comb begin
		ctl.start = (st_q == ST_COMP) && !ctl.busy && !ctl.done;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_BYTE && cnt_q != 3'd0) begin
			buf_q[widx] <= (buf_q[widx] & ~(32'hff << sh)) | ({24'd0, data_q[31:24]} << sh);
		end else if (st_q == ST_PAD) begin
			if (fill_q == LEN_FILL && final_q) begin
				buf_q[14] <= bits[63:32];
				buf_q[15] <= bits[31:0];
			end else begin
				buf_q[widx] <= (buf_q[widx] & ~(32'hff << sh)) | ({24'd0, cur_byte} << sh);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			for (int i = 0; i < 8; i++) hs_q[i] <= INIT_H[i];
			fill_q <= '0;
			tot_q <= '0;
			ovf_q <= 1'b0;
			err_q <= 1'b0;
			data_q <= '0;
			cnt_q <= '0;
			eom_q <= 1'b0;
			padding_q <= 1'b0;
			final_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						data_q <= s_axis_tdata[31:0];
						eom_q <= s_axis_tlast;
						if ({61'd0, in_cnt} > ~tot_q) begin
							ovf_q <= 1'b1;
							cnt_q <= 3'd0;
						end else begin
							cnt_q <= in_cnt;
							tot_q <= tot_q + {61'd0, in_cnt};
						end
						st_q <= ST_BYTE;
					end
				end
				ST_BYTE: begin
					if (cnt_q != 3'd0) begin
						data_q <= {data_q[23:0], 8'h00};
						cnt_q <= cnt_q - 3'd1;
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) st_q <= ST_COMP;
					end else if (eom_q) begin
						err_q <= ovf_q || (tot_q[63:61] != 3'd0);
						data_q <= {PAD_BYTE, 24'd0};
						padding_q <= 1'b0;
						final_q <= 1'b0;
						st_q <= ST_PAD;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					if (fill_q == LEN_FILL && final_q) begin
						fill_q <= '0;
						st_q <= ST_COMP;
					end else begin
						padding_q <= 1'b1;
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) begin
							st_q <= ST_COMP;
						end
						if (fill_q + 6'd1 == LEN_FILL) final_q <= 1'b1;
					end
				end
				ST_COMP: begin
					if (ctl.done) begin
						for (int i = 0; i < 8; i++) hs_q[i] <= h_new[i];
						if (!padding_q && cnt_q != 3'd0) st_q <= ST_BYTE;
						else if (!padding_q) st_q <= eom_q ? ST_BYTE : ST_IDLE;
						else if (final_q && fill_q == 6'd0) begin
							st_q <= ST_OUT;
							oidx_q <= '0;
						end else st_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) hs_q[i] <= INIT_H[i];
							tot_q <= '0;
							ovf_q <= 1'b0;
							padding_q <= 1'b0;
							final_q <= 1'b0;
							eom_q <= 1'b0;
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(oidx_q))
		else $error("digest word lost under stall");
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
	a_core_only_comp: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.busy |-> st_q == ST_COMP) else $error("core running outside compress");

endmodule
`default_nettype wire
